@@ sv/obrb_pkg.sv @@
package obrb_pkg;

    localparam int DEPTH    = 1024;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int PTR_W    = ADDR_W + 1;
    localparam int BYTE_W   = 8;
    localparam int OP_W     = 3;
    localparam int OFF_W    = 10;
    localparam int COUNT_W  = 11;
    localparam int DROP_W   = 32;
    localparam int IDX_W    = 1;
    localparam int IN_W     = 32;
    localparam int OUT_W    = 64;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH    = 3'd0,
        OP_PEEK    = 3'd1,
        OP_CONSUME = 3'd2,
        OP_FIND    = 3'd3,
        OP_CLEAR   = 3'd4,
        OP_STATUS  = 3'd5
    } op_t;

    typedef enum logic [IDX_W-1:0] {
        REG_HEADER_FIRST  = 1'b0,
        REG_HEADER_SECOND = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    typedef struct packed {
        logic [DROP_W-1:0] dropped_count;
        logic [PTR_W-1:0]  fill_level;
        logic [PTR_W-1:0]  position;
        logic              found;
        logic [BYTE_W-1:0] read_byte;
    } result_t;

endpackage

@@ sv/obrb_ram.sv @@
module obrb_ram (
    input  logic                      clk,
    input  obrb_pkg::ram_req_t        req,
    output logic [obrb_pkg::BYTE_W-1:0] rdata
);
    import obrb_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata <= mem[req.raddr];
        end
    end

endmodule

@@ sv/obrb_ctrl.sv @@
module obrb_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [obrb_pkg::OP_W-1:0]    in_op,
    input  logic [obrb_pkg::BYTE_W-1:0]  in_data_byte,
    input  logic [obrb_pkg::OFF_W-1:0]   in_offset,
    input  logic [obrb_pkg::COUNT_W-1:0] in_count,
    input  logic                         cfg_we,
    input  logic [obrb_pkg::IDX_W-1:0]   cfg_index,
    input  logic [obrb_pkg::BYTE_W-1:0]  cfg_data,
    output obrb_pkg::ram_req_t           ram_req,
    input  logic [obrb_pkg::BYTE_W-1:0]  ram_rdata,
    output logic                         res_valid,
    input  logic                         res_ready,
    output obrb_pkg::result_t            res
);
    import obrb_pkg::*;

    state_t            state_reg, state_next;
    op_t               op_reg, op_next;
    logic              hit_reg, hit_next;
    logic [PTR_W-1:0]  pos_reg, pos_next;
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [DROP_W-1:0] drop_reg, drop_next;
    logic [BYTE_W-1:0] hdr_first_reg, hdr_second_reg;
    logic [PTR_W-1:0]  idx_reg, idx_next;
    logic [PTR_W-1:0]  chk_idx_reg, chk_idx_next;
    logic              chk_valid_reg, chk_valid_next;
    logic              prev_valid_reg, prev_valid_next;
    logic [BYTE_W-1:0] prev_byte_reg, prev_byte_next;

    logic [PTR_W-1:0]  fill;
    logic [PTR_W-1:0]  off_ext;
    logic [PTR_W-1:0]  consume_amt;

    assign fill        = wr_ptr_reg - rd_ptr_reg;
    assign off_ext     = PTR_W'(in_offset);
    assign consume_amt = (in_count > fill) ? fill : in_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            drop_reg       <= '0;
            hdr_first_reg  <= '0;
            hdr_second_reg <= '0;
            chk_valid_reg  <= 1'b0;
            prev_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            drop_reg       <= drop_next;
            chk_valid_reg  <= chk_valid_next;
            prev_valid_reg <= prev_valid_next;
            if (cfg_we)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_HEADER_FIRST:  hdr_first_reg  <= cfg_data;
                    REG_HEADER_SECOND: hdr_second_reg <= cfg_data;
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        hit_reg       <= hit_next;
        pos_reg       <= pos_next;
        idx_reg       <= idx_next;
        chk_idx_reg   <= chk_idx_next;
        prev_byte_reg <= prev_byte_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        hit_next        = hit_reg;
        pos_next        = pos_reg;
        wr_ptr_next     = wr_ptr_reg;
        rd_ptr_next     = rd_ptr_reg;
        drop_next       = drop_reg;
        idx_next        = idx_reg;
        chk_idx_next    = chk_idx_reg;
        chk_valid_next  = 1'b0;
        prev_valid_next = prev_valid_reg;
        prev_byte_next  = prev_byte_reg;
        ram_req         = '0;
        in_ready        = 1'b0;
        res_valid       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next    = op_t'(in_op);
                    hit_next   = 1'b0;
                    state_next = ST_EMIT;
                    case (op_t'(in_op))
                        OP_PUSH:
                        begin
                            ram_req.we    = 1'b1;
                            ram_req.waddr = wr_ptr_reg[ADDR_W-1:0];
                            ram_req.wdata = in_data_byte;
                            wr_ptr_next   = wr_ptr_reg + PTR_W'(1);
                            if (fill == PTR_W'(DEPTH))
                            begin
                                rd_ptr_next = rd_ptr_reg + PTR_W'(1);
                                if (drop_reg != '1)
                                begin
                                    drop_next = drop_reg + DROP_W'(1);
                                end
                            end
                        end
                        OP_PEEK:
                        begin
                            hit_next      = off_ext < fill;
                            ram_req.re    = 1'b1;
                            ram_req.raddr = rd_ptr_reg[ADDR_W-1:0] + in_offset;
                        end
                        OP_CONSUME:
                        begin
                            rd_ptr_next = rd_ptr_reg + consume_amt;
                        end
                        OP_FIND:
                        begin
                            if (off_ext + PTR_W'(2) <= fill)
                            begin
                                idx_next        = off_ext;
                                prev_valid_next = 1'b0;
                                state_next      = ST_SEARCH;
                            end
                        end
                        OP_CLEAR:
                        begin
                            wr_ptr_next = '0;
                            rd_ptr_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_SEARCH:
            begin
                if (chk_valid_reg && prev_valid_reg && prev_byte_reg == hdr_first_reg
                    && ram_rdata == hdr_second_reg)
                begin
                    hit_next   = 1'b1;
                    pos_next   = chk_idx_reg - PTR_W'(1);
                    state_next = ST_EMIT;
                end
                else if (!chk_valid_reg && idx_reg >= fill)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    if (chk_valid_reg)
                    begin
                        prev_byte_next  = ram_rdata;
                        prev_valid_next = 1'b1;
                    end
                    if (idx_reg < fill)
                    begin
                        ram_req.re     = 1'b1;
                        ram_req.raddr  = rd_ptr_reg[ADDR_W-1:0] + idx_reg[ADDR_W-1:0];
                        chk_valid_next = 1'b1;
                        chk_idx_next   = idx_reg;
                        idx_next       = idx_reg + PTR_W'(1);
                    end
                end
            end

            ST_EMIT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.read_byte     = (op_reg == OP_PEEK && hit_reg) ? ram_rdata : '0;
        res.found         = hit_reg;
        res.position      = (op_reg == OP_FIND && hit_reg) ? pos_reg : fill;
        res.fill_level    = fill;
        res.dropped_count = drop_reg;
    end

endmodule

@@ sv/overwriting_byte_ring_buffer.sv @@
// Channel   Direction  tdata (low bit up)                              tuser
// s_axis    in         data_byte[7:0] offset[17:8] count[28:18] 0-pad   operation[2:0]
// m_axis    out        read_byte[7:0] found[8] position[19:9]          -
//                      fill_level[30:20] dropped_count[62:31] 0-pad
// cfg       in         cfg_we, cfg_index (0 header_first, 1 header_second), cfg_data
//
// Push, peek, consume, clear and status go from accept through ST_EMIT to the
// output register. A header search that starts in range reads one byte per cycle
// through the single read port of the byte memory.
// One word is in work at a time; the output register holds a finished result
// while the next word is accepted. Reset clears pointers, drop count and header
// bytes; the byte memory is not cleared.
module overwriting_byte_ring_buffer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [obrb_pkg::IN_W-1:0]      s_axis_tdata,  // data_byte, offset, count
    input  logic [obrb_pkg::OP_W-1:0]      s_axis_tuser,  // operation
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [obrb_pkg::OUT_W-1:0]     m_axis_tdata,  // read_byte, found, position,
                                                          // fill_level, dropped_count
    input  logic                           cfg_we,
    input  logic [obrb_pkg::IDX_W-1:0]     cfg_index,
    input  logic [obrb_pkg::BYTE_W-1:0]    cfg_data
);
    import obrb_pkg::*;

    ram_req_t          ram_req;
    logic [BYTE_W-1:0] ram_rdata;
    logic              res_valid;
    logic              res_ready;
    result_t           res;

    logic              out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]  out_data_reg;

    obrb_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    obrb_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_op        (s_axis_tuser),
        .in_data_byte (s_axis_tdata[7:0]),
        .in_offset    (s_axis_tdata[17:8]),
        .in_count     (s_axis_tdata[28:18]),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .ram_req      (ram_req),
        .ram_rdata    (ram_rdata),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= OUT_W'(res);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

@@ sv/obrb_checker.sv @@
module obrb_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [obrb_pkg::OUT_W-1:0]     m_axis_tdata
);
    import obrb_pkg::*;

    assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("result word valid during reset");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result word changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[30:20] <= PTR_W'(DEPTH))
        else $error("fill level above capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[7:0] != '0 |-> m_axis_tdata[8])
        else $error("nonzero read byte without hit");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[8] && m_axis_tdata[19:9] != m_axis_tdata[30:20]
        |-> m_axis_tdata[19:9] + 11'd2 <= m_axis_tdata[30:20])
        else $error("header position outside held bytes");

endmodule

bind overwriting_byte_ring_buffer obrb_checker u_obrb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
